// ===== sv/cds_pkg.sv =====
`default_nettype none
package cds_pkg;

	localparam int MAX_AMOUNT = 65535;

	localparam int KIND_W  = 2;
	localparam int AMT_W   = 16;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;

	localparam int AMT_CAP = (MAX_AMOUNT > 65535) ? 65535 : MAX_AMOUNT;
	localparam int N_W     = $clog2(AMT_CAP * 7 + 1);
	localparam int YEAR_MAX = 9999;

	// y / 100 == (y * 5243) >> 19 for every y up to 9999
	localparam int RECIP_100   = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int CENT_W      = 7;

	localparam logic [KIND_W-1:0] KIND_DAYS   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WEEKS  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MONTHS = 2'd2;
	localparam logic [KIND_W-1:0] KIND_YEARS  = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [AMT_W-1:0]   amount;
		logic [YEAR_W-1:0]  start_year;
		logic [MONTH_W-1:0] start_month;
		logic [DAY_W-1:0]   start_day;
	} in_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  result_year;
		logic [MONTH_W-1:0] result_month;
		logic [DAY_W-1:0]   result_day;
		logic               underflow;
	} out_t;

	// datapath operations
	localparam logic [3:0] OP_NOP   = 4'd0;
	localparam logic [3:0] OP_LOAD  = 4'd1;
	localparam logic [3:0] OP_DIV   = 4'd2;
	localparam logic [3:0] OP_MOD   = 4'd3;
	localparam logic [3:0] OP_CLAMP = 4'd4;
	localparam logic [3:0] OP_DSTEP = 4'd5;
	localparam logic [3:0] OP_YSUB  = 4'd6;
	localparam logic [3:0] OP_MSTEP = 4'd7;
	localparam logic [3:0] OP_M12   = 4'd8;
	localparam logic [3:0] OP_MREM  = 4'd9;
	localparam logic [3:0] OP_OUT   = 4'd10;

	// jump conditions
	localparam logic [3:0] C_NEVER   = 4'd0;
	localparam logic [3:0] C_ALWAYS  = 4'd1;
	localparam logic [3:0] C_NOACC   = 4'd2;
	localparam logic [3:0] C_YEARS   = 4'd3;
	localparam logic [3:0] C_MONTHS  = 4'd4;
	localparam logic [3:0] C_DAYMORE = 4'd5;
	localparam logic [3:0] C_MMORE   = 4'd6;
	localparam logic [3:0] C_M12MORE = 4'd7;
	localparam logic [3:0] C_OUTBUSY = 4'd8;

	localparam int PC_W = 4;

	// program addresses
	localparam logic [PC_W-1:0] A_IDLE   = 4'd0;
	localparam logic [PC_W-1:0] A_DIV    = 4'd1;
	localparam logic [PC_W-1:0] A_MOD    = 4'd2;
	localparam logic [PC_W-1:0] A_CLAMP  = 4'd3;
	localparam logic [PC_W-1:0] A_KIND   = 4'd4;
	localparam logic [PC_W-1:0] A_DAYS   = 4'd5;
	localparam logic [PC_W-1:0] A_DEXIT  = 4'd6;
	localparam logic [PC_W-1:0] A_YSUB   = 4'd7;
	localparam logic [PC_W-1:0] A_YDIV   = 4'd8;
	localparam logic [PC_W-1:0] A_YMOD   = 4'd9;
	localparam logic [PC_W-1:0] A_YCLAMP = 4'd10;
	localparam logic [PC_W-1:0] A_MSTEP  = 4'd11;
	localparam logic [PC_W-1:0] A_M12    = 4'd12;
	localparam logic [PC_W-1:0] A_MREM   = 4'd13;
	localparam logic [PC_W-1:0] A_OUT    = 4'd15;

	typedef struct packed {
		logic [3:0]      op;
		logic [3:0]      cond;
		logic [PC_W-1:0] target;
	} uword_t;

	function automatic uword_t urom(input logic [PC_W-1:0] addr);
		uword_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: A_OUT};
		unique case (addr)
			A_IDLE:   w = '{op: OP_LOAD,  cond: C_NOACC,   target: A_IDLE};
			A_DIV:    w = '{op: OP_DIV,   cond: C_NEVER,   target: A_IDLE};
			A_MOD:    w = '{op: OP_MOD,   cond: C_NEVER,   target: A_IDLE};
			A_CLAMP:  w = '{op: OP_CLAMP, cond: C_YEARS,   target: A_YSUB};
			A_KIND:   w = '{op: OP_NOP,   cond: C_MONTHS,  target: A_MSTEP};
			A_DAYS:   w = '{op: OP_DSTEP, cond: C_DAYMORE, target: A_DAYS};
			A_DEXIT:  w = '{op: OP_NOP,   cond: C_ALWAYS,  target: A_OUT};
			A_YSUB:   w = '{op: OP_YSUB,  cond: C_NEVER,   target: A_IDLE};
			A_YDIV:   w = '{op: OP_DIV,   cond: C_NEVER,   target: A_IDLE};
			A_YMOD:   w = '{op: OP_MOD,   cond: C_NEVER,   target: A_IDLE};
			A_YCLAMP: w = '{op: OP_CLAMP, cond: C_ALWAYS,  target: A_OUT};
			A_MSTEP:  w = '{op: OP_MSTEP, cond: C_MMORE,   target: A_MSTEP};
			A_M12:    w = '{op: OP_M12,   cond: C_M12MORE, target: A_M12};
			A_MREM:   w = '{op: OP_MREM,  cond: C_ALWAYS,  target: A_OUT};
			A_OUT:    w = '{op: OP_OUT,   cond: C_OUTBUSY, target: A_OUT};
			default:  w = '{op: OP_NOP,   cond: C_ALWAYS,  target: A_OUT};
		endcase
		return w;
	endfunction

	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] r;
		case (m)
			4'd2:                      r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/calendar_date_subtract.sv =====
// Years subtract in one step; days and weeks walk back one month boundary at a time until the
// walk ends inside a month; months step single months while the day is above 28, then whole
// years of 12 at a time, then the remainder.
// One item at a time: the next item can be taken from the cycle in which out_valid rises, even while
// that result waits; a later result left waiting holds the sequencer in its output step.
// Reset clears the step counter and the output valid flag.
`default_nettype none
module calendar_date_subtract (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  cds_pkg::in_t   in_data,
	output logic           out_valid,
	input  wire            out_ready,
	output cds_pkg::out_t  out_data
);
	import cds_pkg::*;

	logic [PC_W-1:0]    pc_q;
	uword_t             uw;
	logic               cond_hit;

	logic [KIND_W-1:0]  kind_q;
	logic [N_W-1:0]     n_q;
	logic [YEAR_W-1:0]  y_q;
	logic [MONTH_W-1:0] m_q;
	logic [DAY_W-1:0]   d_q;
	logic               uf_q;
	logic [CENT_W-1:0]  q_q;
	logic [CENT_W-1:0]  c100_q;
	logic [1:0]         c4h_q;

	logic               out_valid_q;
	out_t               out_q;

	logic [AMT_W-1:0]   amt_c;
	logic [YEAR_W-1:0]  y_c;
	logic [MONTH_W-1:0] m_c;
	logic [DAY_W-1:0]   d_c;
	logic [N_W-1:0]     n_c;
	logic               leap;
	logic [DAY_W-1:0]   dim_cur;
	logic [MONTH_W-1:0] m_prev;
	logic [DAY_W-1:0]   dim_prev;
	logic [YEAR_W+13-1:0] recip_prod;
	logic [YEAR_W-1:0]  cent_x100;
	logic [3:0]         n4;

	assign uw        = urom(pc_q);
	assign in_ready  = (pc_q == A_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		amt_c = (32'(in_data.amount) > AMT_CAP) ? AMT_W'(AMT_CAP) : in_data.amount;
		y_c   = (in_data.start_year > YEAR_W'(YEAR_MAX)) ? YEAR_W'(YEAR_MAX)
			: in_data.start_year;
		if (in_data.start_month == '0)
			m_c = 4'd1;
		else if (in_data.start_month > 4'd12)
			m_c = 4'd12;
		else
			m_c = in_data.start_month;
		d_c = (in_data.start_day == '0) ? 5'd1 : in_data.start_day;
		if (in_data.kind == KIND_WEEKS)
			n_c = N_W'({amt_c, 3'b000}) - N_W'(amt_c);
		else
			n_c = N_W'(amt_c);
	end

	assign leap       = (y_q[1:0] == 2'd0) && ((c100_q != '0) || (c4h_q == 2'd0));
	assign dim_cur    = days_in(m_q, leap);
	assign m_prev     = (m_q == 4'd1) ? 4'd12 : m_q - 4'd1;
	assign dim_prev   = days_in(m_prev, leap);
	assign recip_prod = y_q * (YEAR_W+13)'(RECIP_100);
	assign cent_x100  = YEAR_W'(q_q) * YEAR_W'(100);
	assign n4         = n_q[3:0];

	always_comb begin
		unique case (uw.cond)
			C_NEVER:   cond_hit = 1'b0;
			C_ALWAYS:  cond_hit = 1'b1;
			C_NOACC:   cond_hit = !in_valid;
			C_YEARS:   cond_hit = (kind_q == KIND_YEARS);
			C_MONTHS:  cond_hit = (kind_q == KIND_MONTHS);
			C_DAYMORE: cond_hit = (n_q != '0) && !uf_q;
			C_MMORE:   cond_hit = (n_q != '0) && (d_q > 5'd28) && !uf_q;
			C_M12MORE: cond_hit = (32'(n_q) >= 32'd12) && !uf_q;
			C_OUTBUSY: cond_hit = out_valid_q && !out_ready;
			default:   cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_IDLE;
		end else begin
			pc_q <= cond_hit ? uw.target : pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.op == OP_OUT && !cond_hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_NOP: begin
			end
			OP_LOAD: begin
				if (in_valid) begin
					kind_q <= in_data.kind;
					n_q    <= n_c;
					y_q    <= y_c;
					m_q    <= m_c;
					d_q    <= d_c;
					uf_q   <= 1'b0;
				end
			end
			OP_DIV: begin
				q_q <= CENT_W'(recip_prod >> RECIP_SHIFT);
			end
			OP_MOD: begin
				c100_q <= CENT_W'(y_q - cent_x100);
				c4h_q  <= q_q[1:0];
			end
			OP_CLAMP: begin
				if (d_q > dim_cur)
					d_q <= dim_cur;
			end
			OP_DSTEP: begin
				if (cond_hit) begin
					if (n_q < N_W'(d_q)) begin
						d_q <= d_q - DAY_W'(n_q);
						n_q <= '0;
					end else begin
						n_q <= n_q - N_W'(d_q);
						if (m_q == 4'd1) begin
							if (y_q == '0) begin
								uf_q <= 1'b1;
							end else begin
								y_q <= y_q - 1'b1;
								m_q <= 4'd12;
								d_q <= 5'd31;
								if (c100_q == '0) begin
									c100_q <= CENT_W'(99);
									c4h_q  <= c4h_q - 1'b1;
								end else begin
									c100_q <= c100_q - 1'b1;
								end
							end
						end else begin
							m_q <= m_prev;
							d_q <= dim_prev;
						end
					end
				end
			end
			OP_YSUB: begin
				if (32'(n_q) > 32'(y_q))
					uf_q <= 1'b1;
				else
					y_q <= y_q - YEAR_W'(n_q);
			end
			OP_MSTEP: begin
				if (cond_hit) begin
					if (m_q == 4'd1 && y_q == '0) begin
						uf_q <= 1'b1;
					end else begin
						if (m_q == 4'd1) begin
							y_q <= y_q - 1'b1;
							if (c100_q == '0) begin
								c100_q <= CENT_W'(99);
								c4h_q  <= c4h_q - 1'b1;
							end else begin
								c100_q <= c100_q - 1'b1;
							end
						end
						m_q <= m_prev;
						if (d_q > dim_prev)
							d_q <= dim_prev;
						n_q <= n_q - 1'b1;
					end
				end
			end
			OP_M12: begin
				if (cond_hit) begin
					n_q <= n_q - N_W'(12);
					if (y_q == '0)
						uf_q <= 1'b1;
					else
						y_q <= y_q - 1'b1;
				end
			end
			OP_MREM: begin
				if (!uf_q && n4 != 4'd0) begin
					if (n4 >= m_q) begin
						if (y_q == '0) begin
							uf_q <= 1'b1;
						end else begin
							y_q <= y_q - 1'b1;
							m_q <= m_q + 4'd12 - n4;
						end
					end else begin
						m_q <= m_q - n4;
					end
				end
			end
			OP_OUT: begin
				if (!cond_hit) begin
					out_q.result_year  <= uf_q ? '0 : y_q;
					out_q.result_month <= uf_q ? 4'd1 : m_q;
					out_q.result_day   <= uf_q ? 5'd1 : d_q;
					out_q.underflow    <= uf_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cds_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	in_t pending_requests[$];
	out_t expected_dates[$];
	int unsigned mismatches = 0;
	int unsigned requests_sent = 0;
	int unsigned dates_seen = 0;
	int unsigned send_wait = 0;
	int unsigned recv_hold = 0;
	bit backlog_done = 1'b0;

	calendar_date_subtract i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit is_leap(int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned month_days(int unsigned m, int unsigned y);
		int unsigned r;
		case (m)
			2: r = is_leap(y) ? 29 : 28;
			4, 6, 9, 11: r = 30;
			default: r = 31;
		endcase
		return r;
	endfunction

	function automatic out_t date_back(in_t req);
		int unsigned y, m, d, n, idx;
		bit uf;
		out_t r;
		y = req.start_year;
		m = req.start_month;
		d = req.start_day;
		n = req.amount;
		uf = 1'b0;
		if (y > YEAR_MAX) y = YEAR_MAX;
		if (m < 1) m = 1;
		if (m > 12) m = 12;
		if (d < 1) d = 1;
		if (d > month_days(m, y)) d = month_days(m, y);
		if (n > MAX_AMOUNT) n = MAX_AMOUNT;
		case (req.kind) inside
			KIND_DAYS, KIND_WEEKS: begin
				if (req.kind == KIND_WEEKS) n = n * 7;
				while (n > 0 && !uf) begin
					if (n < d) begin
						d = d - n;
						n = 0;
					end else begin
						n = n - d;
						if (m == 1) begin
							if (y == 0) begin
								uf = 1'b1;
							end else begin
								y = y - 1;
								m = 12;
								d = 31;
							end
						end else begin
							m = m - 1;
							d = month_days(m, y);
						end
					end
				end
			end
			KIND_MONTHS: begin
				// clamp can only bite while the day is above 28
				while (n > 0 && d > 28 && !uf) begin
					if (m == 1) begin
						if (y == 0) begin
							uf = 1'b1;
						end else begin
							y = y - 1;
							m = 12;
						end
					end else begin
						m = m - 1;
					end
					if (!uf) begin
						if (d > month_days(m, y)) d = month_days(m, y);
						n = n - 1;
					end
				end
				if (!uf && n > 0) begin
					idx = y * 12 + (m - 1);
					if (n > idx) begin
						uf = 1'b1;
					end else begin
						idx = idx - n;
						y = idx / 12;
						m = idx % 12 + 1;
					end
				end
			end
			default: begin
				if (n > y) begin
					uf = 1'b1;
				end else begin
					y = y - n;
					if (m == 2 && d == 29 && !is_leap(y)) d = 28;
				end
			end
		endcase
		if (uf) begin
			y = 0;
			m = 1;
			d = 1;
		end
		r.result_year = YEAR_W'(y);
		r.result_month = MONTH_W'(m);
		r.result_day = DAY_W'(d);
		r.underflow = uf;
		return r;
	endfunction

	function automatic in_t make_request(logic [KIND_W-1:0] kind, int unsigned amount,
		int unsigned y, int unsigned m, int unsigned d);
		in_t r;
		r.kind = kind;
		r.amount = AMT_W'(amount);
		r.start_year = YEAR_W'(y);
		r.start_month = MONTH_W'(m);
		r.start_day = DAY_W'(d);
		return r;
	endfunction

	function automatic in_t random_request();
		int unsigned sel, y, m, d, dim, amount;
		logic [KIND_W-1:0] kind;
		kind = KIND_W'($urandom_range(0, 3));
		sel = $urandom_range(0, 99);
		if (sel < 90) amount = $urandom_range(0, 400);
		else if (sel < 99) amount = $urandom_range(0, 4000);
		else amount = $urandom_range(0, 65535);
		if ($urandom_range(0, 9) == 0) begin
			// malformed dates
			y = $urandom_range(0, 16383);
			m = $urandom_range(0, 15);
			d = $urandom_range(0, 31);
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 55) y = $urandom_range(0, YEAR_MAX);
			else if (sel < 85) y = $urandom_range(0, 60);
			else y = $urandom_range(YEAR_MAX - 9, YEAR_MAX);
			m = $urandom_range(1, 12);
			dim = month_days(m, y);
			if ($urandom_range(0, 9) < 3) d = $urandom_range(28, dim);
			else d = $urandom_range(1, dim);
		end
		return make_request(kind, amount, y, m, d);
	endfunction

	function automatic int unsigned draw_gap(int unsigned idx);
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (idx >= 600 && idx < 800) return 0;
		if (sel < 60) return 0;
		if (sel < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_dates.push_back(date_back(in_data));
				requests_sent++;
			end
			if (!in_valid || in_ready) begin
				if (send_wait == 0 && pending_requests.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= pending_requests.pop_front();
					send_wait <= draw_gap(requests_sent);
				end else begin
					in_valid <= 1'b0;
					if (send_wait != 0) send_wait <= send_wait - 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_t want;
		int unsigned sel;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_hold <= 0;
		end else begin
			if (out_valid && out_ready) begin
				dates_seen++;
				if (expected_dates.size() == 0) begin
					$error("unexpected item: %p", out_data);
					mismatches++;
				end else begin
					want = expected_dates.pop_front();
					if (out_data.result_year !== want.result_year) begin
						$error("result_year expected %0d got %0d",
							want.result_year, out_data.result_year);
						mismatches++;
					end
					if (out_data.result_month !== want.result_month) begin
						$error("result_month expected %0d got %0d",
							want.result_month, out_data.result_month);
						mismatches++;
					end
					if (out_data.result_day !== want.result_day) begin
						$error("result_day expected %0d got %0d",
							want.result_day, out_data.result_day);
						mismatches++;
					end
					if (out_data.underflow !== want.underflow) begin
						$error("underflow expected %0d got %0d",
							want.underflow, out_data.underflow);
						mismatches++;
					end
				end
			end
			sel = $urandom_range(0, 99);
			if (recv_hold != 0) begin
				out_ready <= 1'b0;
				recv_hold <= recv_hold - 1;
			end else if (!backlog_done && dates_seen >= 300) begin
				// long hold-off so the block backs up into its input
				backlog_done <= 1'b1;
				out_ready <= 1'b0;
				recv_hold <= 3000;
			end else if ((dates_seen >= 600 && dates_seen < 800) || sel < 70) begin
				out_ready <= 1'b1;
			end else if (sel < 95) begin
				out_ready <= 1'b0;
				recv_hold <= $urandom_range(0, 2);
			end else begin
				out_ready <= 1'b0;
				recv_hold <= $urandom_range(10, 60);
			end
		end
	end

	initial begin
		pending_requests.push_back(make_request(KIND_DAYS, 0, 2024, 3, 15));
		pending_requests.push_back(make_request(KIND_DAYS, 1, 2024, 1, 1));
		pending_requests.push_back(make_request(KIND_DAYS, 1, 2024, 3, 1));
		pending_requests.push_back(make_request(KIND_WEEKS, 1, 2024, 3, 5));
		pending_requests.push_back(make_request(KIND_WEEKS, 0, 2000, 6, 30));
		pending_requests.push_back(make_request(KIND_DAYS, 65535, 9999, 12, 31));
		pending_requests.push_back(make_request(KIND_WEEKS, 65535, 9999, 12, 31));
		pending_requests.push_back(make_request(KIND_MONTHS, 1, 2023, 3, 31));
		pending_requests.push_back(make_request(KIND_MONTHS, 1, 2000, 1, 31));
		pending_requests.push_back(make_request(KIND_MONTHS, 65535, 9999, 12, 31));
		pending_requests.push_back(make_request(KIND_MONTHS, 13, 0, 12, 31));
		pending_requests.push_back(make_request(KIND_YEARS, 1, 2024, 2, 29));
		pending_requests.push_back(make_request(KIND_YEARS, 400, 2400, 2, 29));
		pending_requests.push_back(make_request(KIND_YEARS, 2000, 2000, 2, 29));
		pending_requests.push_back(make_request(KIND_YEARS, 9999, 9999, 6, 15));
		pending_requests.push_back(make_request(KIND_YEARS, 65535, 9999, 12, 31));
		pending_requests.push_back(make_request(KIND_YEARS, 0, 0, 1, 1));
		pending_requests.push_back(make_request(KIND_DAYS, 1, 0, 1, 1));
		pending_requests.push_back(make_request(KIND_DAYS, 31, 0, 1, 31));
		pending_requests.push_back(make_request(KIND_DAYS, 0, 16383, 15, 31));
		pending_requests.push_back(make_request(KIND_MONTHS, 0, 2010, 0, 0));
		pending_requests.push_back(make_request(KIND_DAYS, 0, 2023, 2, 31));
		pending_requests.push_back(make_request(KIND_DAYS, 0, 1900, 2, 29));
		pending_requests.push_back(make_request(KIND_DAYS, 366, 2000, 12, 31));
		repeat (1500) pending_requests.push_back(random_request());
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_dates.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_dates.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
